// ===== hdl/dccpb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dccpb_pkg
// Shared types and constants for the DCC packet builder: the command word,
// the packet byte word and the built packet that passes from front to back.
// ----------------------------------------------------------------------------
package dccpb_pkg;

  // Command codes
  localparam logic [2:0] CMD_SPEED14  = 3'd0;
  localparam logic [2:0] CMD_SPEED28  = 3'd1;
  localparam logic [2:0] CMD_SPEED128 = 3'd2;
  localparam logic [2:0] CMD_FUNC_GRP = 3'd3;
  localparam logic [2:0] CMD_EXT_FUNC = 3'd4;

  // Function group codes
  localparam logic [1:0] GRP_ONE   = 2'd1;
  localparam logic [1:0] GRP_TWO   = 2'd2;
  localparam logic [1:0] GRP_THREE = 2'd3;

  // Address limits
  localparam logic [13:0] SHORT_ADDR_MAX = 14'd127;
  localparam logic [13:0] LONG_ADDR_MAX  = 14'd10239;

  // Byte patterns
  localparam logic [7:0] SPEED_BASE    = 8'b0100_0000;
  localparam logic [7:0] DIR_BIT       = 8'b0010_0000;
  localparam logic [7:0] ADV_OP_128    = 8'b0011_1111;
  localparam logic [7:0] GRP_ONE_BASE  = 8'b1000_0000;
  localparam logic [7:0] GRP_TWO_BASE  = 8'b1011_0000;
  localparam logic [7:0] GRP_THR_BASE  = 8'b1010_0000;
  localparam logic [7:0] EXT_FUNC_BASE = 8'b1101_1110;
  localparam logic [7:0] LONG_ADDR_TAG = 8'b1100_0000;

  localparam int unsigned PKT_DEPTH = 5;

  typedef struct packed {
    logic [2:0]  command;
    logic [13:0] loco_address;
    logic        forward;
    logic [6:0]  speed_code;
    logic [1:0]  group_number;
    logic [7:0]  function_mask;
    logic        upper_bank;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
    logic       error;
  } byte_word_t;

  // Built packet; an error packet has length one and a zero byte
  typedef struct packed {
    logic [PKT_DEPTH-1:0][7:0] bytes;
    logic [2:0]                len;
    logic                      err;
  } packet_t;

endpackage
`default_nettype wire

// ===== hdl/dccpb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dccpb_front
// Accepts command words, checks them and builds the whole packet with its
// checksum into a holding register, then hands it to the queue.
// ----------------------------------------------------------------------------
module dccpb_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  dccpb_pkg::cmd_word_t in_word_i,
  output logic                 pkt_valid_o,
  input  wire                  pkt_full_i,
  output dccpb_pkg::packet_t   pkt_o
);
  import dccpb_pkg::*;

  logic       hold_valid_q, hold_valid_d;
  packet_t    hold_q;
  packet_t    built;
  logic       ok;
  logic       addr_ok, addr_long;
  logic [7:0] a0, a1, d0, d1, sum;
  logic       data_two;
  logic       accept;

  // Decode address
  always_comb begin
    addr_ok   = (in_word_i.loco_address != 14'd0) &&
                (in_word_i.loco_address <= LONG_ADDR_MAX);
    addr_long = in_word_i.loco_address > SHORT_ADDR_MAX;
    if (addr_long) begin
      a0 = LONG_ADDR_TAG | {2'b00, in_word_i.loco_address[13:8]};
      a1 = in_word_i.loco_address[7:0];
    end else begin
      a0 = {1'b0, in_word_i.loco_address[6:0]};
      a1 = 8'h00;
    end
  end

  // Classify command and form data bytes
  always_comb begin
    ok       = addr_ok;
    d0       = 8'h00;
    d1       = 8'h00;
    data_two = 1'b0;
    unique case (in_word_i.command)
      CMD_SPEED14: begin
        if (addr_long || in_word_i.speed_code > 7'd15) ok = 1'b0;
        d0 = SPEED_BASE | (in_word_i.forward ? DIR_BIT : 8'h00) |
             {4'b0000, in_word_i.speed_code[3:0]};
      end
      CMD_SPEED28: begin
        if (in_word_i.speed_code > 7'd31) ok = 1'b0;
        d0 = SPEED_BASE | (in_word_i.forward ? DIR_BIT : 8'h00) |
             {3'b000, in_word_i.speed_code[4:0]};
      end
      CMD_SPEED128: begin
        d0       = ADV_OP_128;
        d1       = {in_word_i.forward, in_word_i.speed_code};
        data_two = 1'b1;
      end
      CMD_FUNC_GRP: begin
        unique case (in_word_i.group_number)
          GRP_ONE: begin
            if (in_word_i.function_mask > 8'h1F) ok = 1'b0;
            d0 = GRP_ONE_BASE | {3'b000, in_word_i.function_mask[4:0]};
          end
          GRP_TWO: begin
            if (in_word_i.function_mask > 8'h0F) ok = 1'b0;
            d0 = GRP_TWO_BASE | {4'b0000, in_word_i.function_mask[3:0]};
          end
          GRP_THREE: begin
            if (in_word_i.function_mask > 8'h0F) ok = 1'b0;
            d0 = GRP_THR_BASE | {4'b0000, in_word_i.function_mask[3:0]};
          end
          default: ok = 1'b0;
        endcase
      end
      CMD_EXT_FUNC: begin
        d0       = EXT_FUNC_BASE | {7'd0, in_word_i.upper_bank};
        d1       = in_word_i.function_mask;
        data_two = 1'b1;
      end
      default: ok = 1'b0;
    endcase
  end

  // Place bytes and checksum
  always_comb begin
    sum         = a0 ^ a1 ^ d0 ^ d1;
    built.bytes = '0;
    built.err   = ~ok;
    built.len   = 3'd1;
    if (ok) begin
      built.bytes[0] = a0;
      case ({addr_long, data_two})
        2'b00: begin
          built.bytes[1] = d0;
          built.bytes[2] = sum;
          built.len      = 3'd3;
        end
        2'b01: begin
          built.bytes[1] = d0;
          built.bytes[2] = d1;
          built.bytes[3] = sum;
          built.len      = 3'd4;
        end
        2'b10: begin
          built.bytes[1] = a1;
          built.bytes[2] = d0;
          built.bytes[3] = sum;
          built.len      = 3'd4;
        end
        default: begin
          built.bytes[1] = a1;
          built.bytes[2] = d0;
          built.bytes[3] = d1;
          built.bytes[4] = sum;
          built.len      = 3'd5;
        end
      endcase
    end
  end

  // Hold the built packet until the queue takes it
  assign in_stall_o = hold_valid_q & pkt_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (hold_valid_q && !pkt_full_i) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= built;
    end
  end

  assign pkt_valid_o = hold_valid_q;
  assign pkt_o       = hold_q;

endmodule
`default_nettype wire

// ===== hdl/dccpb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dccpb_queue
// Two-entry queue of built packets between the front and the emitter.
// ----------------------------------------------------------------------------
module dccpb_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  dccpb_pkg::packet_t push_pkt_i,
  output logic               full_o,
  input  wire                pop_i,
  output logic               head_valid_o,
  output dccpb_pkg::packet_t head_pkt_o
);
  import dccpb_pkg::*;

  packet_t    entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o       = count_q == 2'd2;
  assign head_valid_o = count_q != 2'd0;
  assign head_pkt_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_pkt_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dccpb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dccpb_back
// Emitter: takes queued packets and sends them one byte word per cycle
// unless stalled, through an output register, marking the final byte.
// ----------------------------------------------------------------------------
module dccpb_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    head_valid_i,
  input  dccpb_pkg::packet_t     head_pkt_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output dccpb_pkg::byte_word_t  out_word_o
);
  import dccpb_pkg::*;

  packet_t    pkt_q, pkt_d;
  logic [2:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       out_valid_q, out_valid_d;
  byte_word_t out_q, out_d;
  logic       advance, is_last;

  assign advance = ~out_valid_q | ~out_stall_i;
  assign is_last = idx_q == (pkt_q.len - 3'd1);
  assign pop_o   = head_valid_i & (~busy_q | (advance & is_last));

  // Emit current byte and load the next packet
  always_comb begin
    pkt_d       = pkt_q;
    idx_d       = idx_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        out_d.packet_byte = pkt_q.bytes[idx_q];
        out_d.last_byte   = is_last;
        out_d.error       = pkt_q.err;
        idx_d             = idx_q + 3'd1;
        if (is_last) begin
          busy_d = 1'b0;
        end
      end
    end
    if (pop_o) begin
      pkt_d  = head_pkt_i;
      idx_d  = 3'd0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

// ===== hdl/dcc_packet_builder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcc_packet_builder_unit
// A packet's first byte word passes the holding register, a queue entry, the
// emitter's packet register and its single output register. Throughput: one
// byte word per cycle while not stalled; a packet gives 3 to 5, an error one.
// A new command is taken every cycle while the two-entry packet queue has room.
// Reset (rst_ni low, asynchronous) empties the holding stage, queue and output.
// ----------------------------------------------------------------------------
module dcc_packet_builder_unit (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  dccpb_pkg::cmd_word_t  in_word_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output dccpb_pkg::byte_word_t out_word_o
);
  import dccpb_pkg::*;

  logic    pkt_valid, q_full, pop, head_valid;
  packet_t pkt, head_pkt;

  // Build packets
  dccpb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .pkt_valid_o (pkt_valid),
    .pkt_full_i  (q_full),
    .pkt_o       (pkt)
  );

  // Buffer packets
  dccpb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (pkt_valid),
    .push_pkt_i   (pkt),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_pkt_o   (head_pkt)
  );

  // Emit byte words
  dccpb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_pkt_i   (head_pkt),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule
`default_nettype wire

// ===== tb/dcc_packet_builder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dcc_packet_builder_checker
// Watches both channels of the DCC packet builder. Each accepted command word
// is turned into its expected packet bytes (address, data, XOR checksum, or a
// single error word), and every accepted byte word is compared with the
// oldest expected one.
// ----------------------------------------------------------------------------
module dcc_packet_builder_checker
  import dccpb_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  input  wire          in_stall_i,
  input  cmd_word_t    in_word_i,
  input  wire          out_valid_i,
  input  wire          out_stall_i,
  input  byte_word_t   out_word_i,
  output int unsigned  pending_o,
  output int unsigned  mismatch_o
);

  byte_word_t expected_bytes[$];
  byte_word_t wanted;

  // Build the packet for one command and queue its byte words
  task automatic predict_packet(input cmd_word_t cmd);
    logic [7:0] pkt [0:PKT_DEPTH-1];
    int         n;
    logic       bad;
    logic [7:0] sum;
    byte_word_t w;
    n   = 0;
    bad = 1'b0;
    sum = 8'h00;
    if (cmd.loco_address == '0 || cmd.loco_address > LONG_ADDR_MAX) begin
      bad = 1'b1;
    end else if (cmd.loco_address <= SHORT_ADDR_MAX) begin
      pkt[0] = cmd.loco_address[7:0];
      n = 1;
    end else begin
      pkt[0] = LONG_ADDR_TAG | {2'b00, cmd.loco_address[13:8]};
      pkt[1] = cmd.loco_address[7:0];
      n = 2;
    end
    if (!bad) begin
      case (cmd.command)
        CMD_SPEED14: begin
          if (n != 1 || cmd.speed_code > 7'd15) begin
            bad = 1'b1;
          end else begin
            pkt[n] = SPEED_BASE | (cmd.forward ? DIR_BIT : 8'h00)
                     | {4'h0, cmd.speed_code[3:0]};
            n++;
          end
        end
        CMD_SPEED28: begin
          if (cmd.speed_code > 7'd31) begin
            bad = 1'b1;
          end else begin
            pkt[n] = SPEED_BASE | (cmd.forward ? DIR_BIT : 8'h00)
                     | {3'h0, cmd.speed_code[4:0]};
            n++;
          end
        end
        CMD_SPEED128: begin
          pkt[n]     = ADV_OP_128;
          pkt[n + 1] = {cmd.forward, cmd.speed_code};
          n += 2;
        end
        CMD_FUNC_GRP: begin
          case (cmd.group_number)
            GRP_ONE: begin
              if (cmd.function_mask > 8'h1F) bad = 1'b1;
              else pkt[n] = GRP_ONE_BASE | cmd.function_mask;
            end
            GRP_TWO: begin
              if (cmd.function_mask > 8'h0F) bad = 1'b1;
              else pkt[n] = GRP_TWO_BASE | cmd.function_mask;
            end
            GRP_THREE: begin
              if (cmd.function_mask > 8'h0F) bad = 1'b1;
              else pkt[n] = GRP_THR_BASE | cmd.function_mask;
            end
            default: bad = 1'b1;
          endcase
          n++;
        end
        CMD_EXT_FUNC: begin
          pkt[n]     = EXT_FUNC_BASE | {7'h00, cmd.upper_bank};
          pkt[n + 1] = cmd.function_mask;
          n += 2;
        end
        default: bad = 1'b1;
      endcase
    end
    if (bad) begin
      w.packet_byte = 8'h00;
      w.last_byte   = 1'b1;
      w.error       = 1'b1;
      expected_bytes.push_back(w);
    end else begin
      for (int i = 0; i < n; i++) sum ^= pkt[i];
      pkt[n] = sum;
      n++;
      for (int i = 0; i < n; i++) begin
        w.packet_byte = pkt[i];
        w.last_byte   = (i == n - 1);
        w.error       = 1'b0;
        expected_bytes.push_back(w);
      end
    end
  endtask

  // Predict on every accepted command, compare every accepted byte word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_bytes.delete();
      pending_o  <= 0;
      mismatch_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_packet(in_word_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          mismatch_o = mismatch_o + 1;
          if (mismatch_o <= 10)
            $display("%0t: byte word byte=%h last=%b err=%b with none expected",
                     $realtime, out_word_i.packet_byte, out_word_i.last_byte,
                     out_word_i.error);
        end else begin
          wanted = expected_bytes.pop_front();
          if (out_word_i !== wanted) begin
            mismatch_o = mismatch_o + 1;
            if (mismatch_o <= 10)
              $display("%0t: mismatch: exp byte=%h last=%b err=%b, got byte=%h last=%b err=%b",
                       $realtime, wanted.packet_byte, wanted.last_byte, wanted.error,
                       out_word_i.packet_byte, out_word_i.last_byte,
                       out_word_i.error);
          end
        end
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule

// ===== tb/tb_dcc_packet_builder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dcc_packet_builder_unit
// Drives locomotive commands into the DCC packet builder: a directed set over
// the field limits and every command kind, then random commands that are
// mostly well formed. Both sides idle at random; a checker predicts and
// compares the packet bytes, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dcc_packet_builder_unit;
  import dccpb_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int          N_RANDOM   = 280;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  cmd_word_t   in_word;
  logic        out_valid;
  logic        out_stall;
  byte_word_t  out_word;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          quiet;

  dcc_packet_builder_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  dcc_packet_builder_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .pending_o   (pending),
    .mismatch_o  (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the byte channel about one cycle in ten, except in the quiet stretch
  always @(posedge clk_i) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 10);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic cmd_word_t make_cmd(input logic [2:0] c, input logic [13:0] a,
                                         input logic f, input logic [6:0] s,
                                         input logic [1:0] g, input logic [7:0] m,
                                         input logic u);
    cmd_word_t w;
    w.command       = c;
    w.loco_address  = a;
    w.forward       = f;
    w.speed_code    = s;
    w.group_number  = g;
    w.function_mask = m;
    w.upper_bank    = u;
    return w;
  endfunction

  // Mostly well-formed commands with random content, the rest raw noise
  function automatic cmd_word_t random_cmd();
    logic [63:0] r;
    cmd_word_t   w;
    r = {$urandom, $urandom};
    w = r[$bits(cmd_word_t)-1:0];
    if ($urandom_range(0, 99) < 80) begin
      w.command = 3'($urandom_range(CMD_SPEED14, CMD_EXT_FUNC));
      case ($urandom_range(0, 3))
        0:       w.loco_address = 14'($urandom_range(1, SHORT_ADDR_MAX));
        3: begin
          case ($urandom_range(0, 3))
            0:       w.loco_address = 14'd1;
            1:       w.loco_address = SHORT_ADDR_MAX;
            2:       w.loco_address = SHORT_ADDR_MAX + 14'd1;
            default: w.loco_address = LONG_ADDR_MAX;
          endcase
        end
        default: w.loco_address = 14'($urandom_range(SHORT_ADDR_MAX + 1, LONG_ADDR_MAX));
      endcase
      case (w.command)
        CMD_SPEED14: begin
          if (w.loco_address > SHORT_ADDR_MAX)
            w.loco_address = 14'($urandom_range(1, SHORT_ADDR_MAX));
          w.speed_code = 7'($urandom_range(0, 15));
        end
        CMD_SPEED28: w.speed_code = 7'($urandom_range(0, 31));
        CMD_FUNC_GRP: begin
          w.group_number = 2'($urandom_range(GRP_ONE, GRP_THREE));
          if (w.group_number == GRP_ONE) w.function_mask = 8'($urandom_range(0, 8'h1F));
          else w.function_mask = 8'($urandom_range(0, 8'h0F));
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  // Offer one command word, idling first now and then, and hold it until taken
  task automatic send_cmd(input cmd_word_t w);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Hold off the command side until every expected byte word has arrived
  task automatic drain_packets();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    quiet     = 1'b0;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field limits, every command kind and each invalid case
    send_cmd(make_cmd(CMD_SPEED14, 14'd1, 1'b0, 7'd0, 2'd0, 8'h00, 1'b0));
    send_cmd(make_cmd(CMD_SPEED14, SHORT_ADDR_MAX, 1'b1, 7'd15, 2'd3, 8'hFF, 1'b1));
    send_cmd(make_cmd(CMD_SPEED14, SHORT_ADDR_MAX, 1'b1, 7'd16, 2'd0, 8'h00, 1'b0));
    send_cmd(make_cmd(CMD_SPEED14, SHORT_ADDR_MAX + 14'd1, 1'b0, 7'd3, 2'd0, 8'h00, 1'b0));
    send_cmd(make_cmd(CMD_SPEED28, SHORT_ADDR_MAX + 14'd1, 1'b1, 7'd31, 2'd0, 8'h00, 1'b0));
    send_cmd(make_cmd(CMD_SPEED28, LONG_ADDR_MAX, 1'b0, 7'd32, 2'd0, 8'h00, 1'b0));
    send_cmd(make_cmd(CMD_SPEED128, LONG_ADDR_MAX, 1'b1, 7'd127, 2'd0, 8'h00, 1'b0));
    send_cmd(make_cmd(CMD_SPEED128, 14'd3, 1'b0, 7'd0, 2'd0, 8'h00, 1'b0));
    send_cmd(make_cmd(CMD_SPEED28, 14'd0, 1'b0, 7'd5, 2'd0, 8'h00, 1'b0));
    send_cmd(make_cmd(CMD_SPEED128, LONG_ADDR_MAX + 14'd1, 1'b1, 7'd9, 2'd0, 8'h00, 1'b0));
    send_cmd(make_cmd(CMD_EXT_FUNC, 14'h3FFF, 1'b1, 7'h7F, 2'd3, 8'hFF, 1'b1));
    send_cmd(make_cmd(CMD_FUNC_GRP, 14'd5, 1'b0, 7'd0, GRP_ONE, 8'h1F, 1'b0));
    send_cmd(make_cmd(CMD_FUNC_GRP, 14'd5, 1'b0, 7'd0, GRP_ONE, 8'h20, 1'b0));
    send_cmd(make_cmd(CMD_FUNC_GRP, 14'd77, 1'b0, 7'd0, GRP_TWO, 8'h0F, 1'b0));
    send_cmd(make_cmd(CMD_FUNC_GRP, 14'd77, 1'b0, 7'd0, GRP_TWO, 8'h10, 1'b0));
    send_cmd(make_cmd(CMD_FUNC_GRP, 14'd4660, 1'b1, 7'd0, GRP_THREE, 8'h0F, 1'b0));
    send_cmd(make_cmd(CMD_FUNC_GRP, 14'd4660, 1'b1, 7'd0, GRP_THREE, 8'h10, 1'b0));
    send_cmd(make_cmd(CMD_FUNC_GRP, 14'd9, 1'b0, 7'd0, 2'd0, 8'h00, 1'b0));
    send_cmd(make_cmd(CMD_EXT_FUNC, 14'd1, 1'b0, 7'd0, 2'd0, 8'h00, 1'b0));
    send_cmd(make_cmd(CMD_EXT_FUNC, LONG_ADDR_MAX, 1'b1, 7'd0, 2'd0, 8'hFF, 1'b1));
    send_cmd(make_cmd(3'd5, 14'd10, 1'b0, 7'd1, GRP_ONE, 8'h01, 1'b0));
    send_cmd(make_cmd(3'd6, 14'd200, 1'b1, 7'd2, GRP_TWO, 8'h02, 1'b1));
    send_cmd(make_cmd(3'd7, LONG_ADDR_MAX, 1'b1, 7'd3, GRP_THREE, 8'h03, 1'b0));
    drain_packets();

    // Random commands, with a stretch where neither side idles
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= 120 && i < 200);
      send_cmd(random_cmd());
    end
    quiet = 1'b0;
    drain_packets();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
